// ----- rtl/gtc_pkg.sv -----
// Package for the GTP-U tunnel classifier: item and result words, job words,
// table entry layouts and protocol constants. Depends on nothing.
package gtc_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] GTPU_PORT_DEF  = 16'd2152;

	localparam logic [1:0] FUNC_FRAME  = 2'd0;
	localparam logic [1:0] FUNC_WRITE  = 2'd1;
	localparam logic [1:0] FUNC_DELETE = 2'd2;
	localparam logic [1:0] FUNC_READ   = 2'd3;

	localparam logic [1:0] KIND_VERDICT  = 2'd0;
	localparam logic [1:0] KIND_STATUS   = 2'd1;
	localparam logic [1:0] KIND_COUNTERS = 2'd2;

	localparam logic [1:0] VERDICT_PASS = 2'd0;
	localparam logic [1:0] VERDICT_MARK = 2'd1;
	localparam logic [1:0] VERDICT_DROP = 2'd2;

	localparam logic [1:0] ACTION_MARK = 2'd0;
	localparam logic [1:0] ACTION_DROP = 2'd1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [31:0] lookup_teid;
		logic [1:0]  policy_action;
		logic [31:0] policy_class;
	} item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  verdict;
		logic [31:0] mark_value;
		logic [31:0] frame_teid;
		logic        is_tunnel;
		logic [63:0] packet_count;
		logic [63:0] octet_count;
		logic [63:0] drop_count;
		logic [1:0]  op_status;
	} result_t;

	// One job handed from the parser to the table engine.
	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] len;
		logic        tunnel;
		logic [31:0] key;
		logic [1:0]  act;
		logic [31:0] cls;
	} job_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [1:0]  act;
		logic [31:0] cls;
	} pol_ent_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] key;
		logic [63:0] pkt;
		logic [63:0] oct;
		logic [63:0] drp;
	} st_ent_t;

	typedef struct packed {
		logic full;
		logic clearing;
	} front_ctl_t;

endpackage

// ----- rtl/gtc_queue.sv -----
// Small job queue between the frame parser and the table engine.
// Depends on gtc_pkg for the job word and the queue depth.
module gtc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  gtc_pkg::job_t     push_job,
	input  logic              pop,
	output logic              full,
	output logic              nonempty,
	output gtc_pkg::job_t     head
);

	localparam int unsigned PW = $clog2(gtc_pkg::QUEUE_DEPTH);

	gtc_pkg::job_t   mem_q [gtc_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [PW:0]     cnt_q;

	assign full     = (cnt_q == (PW+1)'(gtc_pkg::QUEUE_DEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(gtc_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(gtc_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/gtc_front.sv -----
// Front end: takes items, parses Ethernet/IPv4/UDP/GTP-U headers on the fly
// and emits one job per finished frame or table operation. Uses gtc_pkg.
module gtc_front #(
	parameter int unsigned HEADER_BYTES = 96
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  gtc_pkg::item_t      item,
	input  logic [15:0]         tunnel_port,
	input  gtc_pkg::front_ctl_t ctl,
	output logic                job_push,
	output gtc_pkg::job_t       job
);

	logic [15:0] pos_q;
	logic [15:0] et_q, sp_q, dp_q;
	logic [3:0]  ihl_q;
	logic [7:0]  proto_q;
	logic [31:0] teid_q;

	logic        acc, frm, cap;
	logic [15:0] p, len_n, avail, udp;
	logic [15:0] et_n, sp_n, dp_n;
	logic [3:0]  ihl_n;
	logic [7:0]  proto_n, b;
	logic [31:0] teid_n;
	logic        tunnel;

	assign item_stall = ctl.full || ctl.clearing;
	assign acc        = item_valid && !item_stall;
	assign frm        = acc && (item.func == gtc_pkg::FUNC_FRAME);

	always_comb begin
		p       = pos_q;
		b       = item.data_byte;
		cap     = frm && (p < 16'(HEADER_BYTES));
		ihl_n   = (cap && p == 16'd14) ? b[3:0] : ihl_q;
		udp     = 16'd14 + {10'd0, ihl_n, 2'b00};
		et_n    = et_q;
		proto_n = proto_q;
		sp_n    = sp_q;
		dp_n    = dp_q;
		teid_n  = teid_q;
		if (cap) begin
			if (p == 16'd12) et_n[15:8] = b;
			if (p == 16'd13) et_n[7:0] = b;
			if (p == 16'd23) proto_n = b;
			if (p == udp) sp_n[15:8] = b;
			if (p == udp + 16'd1) sp_n[7:0] = b;
			if (p == udp + 16'd2) dp_n[15:8] = b;
			if (p == udp + 16'd3) dp_n[7:0] = b;
			if (p == udp + 16'd12) teid_n[31:24] = b;
			if (p == udp + 16'd13) teid_n[23:16] = b;
			if (p == udp + 16'd14) teid_n[15:8] = b;
			if (p == udp + 16'd15) teid_n[7:0] = b;
		end
		len_n  = (pos_q == 16'hFFFF) ? pos_q : pos_q + 16'd1;
		avail  = (len_n < 16'(HEADER_BYTES)) ? len_n : 16'(HEADER_BYTES);
		tunnel = (avail >= 16'd14) && (et_n == gtc_pkg::ETHERTYPE_IPV4)
			&& (avail >= 16'd34) && (proto_n == gtc_pkg::PROTO_UDP)
			&& (udp + 16'd8 <= avail)
			&& ((sp_n == tunnel_port) || (dp_n == tunnel_port))
			&& (udp + 16'd16 <= avail);
	end

	assign job_push   = acc && ((item.func != gtc_pkg::FUNC_FRAME) || item.last_byte);
	assign job.func   = item.func;
	assign job.len    = len_n;
	assign job.tunnel = tunnel;
	assign job.key    = (item.func == gtc_pkg::FUNC_FRAME) ? teid_n : item.lookup_teid;
	assign job.act    = item.policy_action;
	assign job.cls    = item.policy_class;

	always_ff @(posedge clk) begin
		if (frm) begin
			et_q    <= et_n;
			ihl_q   <= ihl_n;
			proto_q <= proto_n;
			sp_q    <= sp_n;
			dp_q    <= dp_n;
			teid_q  <= teid_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (frm) begin
			pos_q <= item.last_byte ? 16'd0 : len_n;
		end
	end

endmodule

// ----- rtl/gtc_back.sv -----
// Back end: scans the policy and stats tables linearly for each job but a
// non-tunnel frame, updates them, registers the result word. Uses gtc_pkg.
module gtc_back #(
	parameter int unsigned TABLE_ENTRIES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_ready,
	input  gtc_pkg::job_t     job,
	output logic              job_pop,
	output logic              clearing,
	output logic              result_valid,
	input  logic              result_stall,
	output gtc_pkg::result_t  result
);

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_APPLY} state_t;

	gtc_pkg::pol_ent_t pol_mem [TABLE_ENTRIES];
	gtc_pkg::st_ent_t  st_mem  [TABLE_ENTRIES];
	gtc_pkg::pol_ent_t pol_rd_s1, pol_wd;
	gtc_pkg::st_ent_t  st_rd_s1, st_wd;
	logic              pol_we, st_we;
	logic [AW-1:0]     pol_wa, st_wa;

	state_t            state_q;
	logic [AW-1:0]     scan_q, addr_s1;
	logic              issue_q, rd_vld_s1, last_s1;
	logic              p_hit_q, p_free_q, s_hit_q, s_free_q;
	logic [AW-1:0]     p_idx_q, p_fidx_q, s_idx_q, s_fidx_q;
	logic [1:0]        p_act_q;
	logic [31:0]       p_cls_q;
	logic [63:0]       s_pkt_q, s_oct_q, s_drp_q;
	logic              res_valid_q;
	gtc_pkg::result_t  res_q, res_n;
	logic              fire, drop;

	assign clearing     = (state_q == ST_CLEAR);
	assign result_valid = res_valid_q;
	assign result       = res_q;
	assign fire         = (state_q == ST_APPLY) && (!res_valid_q || !result_stall);
	assign job_pop      = fire;
	assign drop         = p_hit_q && (p_act_q == gtc_pkg::ACTION_DROP);

	always_ff @(posedge clk) begin
		if (pol_we) pol_mem[pol_wa] <= pol_wd;
		if (st_we) st_mem[st_wa] <= st_wd;
		pol_rd_s1 <= pol_mem[scan_q];
		st_rd_s1  <= st_mem[scan_q];
	end

	always_comb begin
		pol_we = 1'b0;
		pol_wa = p_idx_q;
		pol_wd = '{valid: 1'b1, key: job.key, act: job.act, cls: job.cls};
		st_we  = 1'b0;
		st_wa  = s_idx_q;
		st_wd  = '{valid: 1'b1, key: job.key, pkt: s_pkt_q + 64'd1,
			oct: s_oct_q + {48'd0, job.len}, drp: s_drp_q + {63'd0, drop}};
		res_n  = '0;
		if (state_q == ST_CLEAR) begin
			pol_we = 1'b1;
			pol_wa = scan_q;
			pol_wd = '0;
			st_we  = 1'b1;
			st_wa  = scan_q;
			st_wd  = '0;
		end
		case (job.func)
			gtc_pkg::FUNC_FRAME: begin
				res_n.result_kind = gtc_pkg::KIND_VERDICT;
				if (job.tunnel) begin
					res_n.is_tunnel  = 1'b1;
					res_n.frame_teid = job.key;
					if (s_hit_q) begin
						st_we = fire;
					end else if (s_free_q) begin
						st_we = fire;
						st_wa = s_fidx_q;
						st_wd.pkt = 64'd1;
						st_wd.oct = {48'd0, job.len};
						st_wd.drp = {63'd0, drop};
					end
					if (drop) begin
						res_n.verdict = gtc_pkg::VERDICT_DROP;
					end else if (p_hit_q && p_act_q == gtc_pkg::ACTION_MARK) begin
						res_n.verdict    = gtc_pkg::VERDICT_MARK;
						res_n.mark_value = p_cls_q;
					end
				end
			end
			gtc_pkg::FUNC_WRITE: begin
				res_n.result_kind = gtc_pkg::KIND_STATUS;
				if (p_hit_q) begin
					pol_we = fire;
				end else if (p_free_q) begin
					pol_we = fire;
					pol_wa = p_fidx_q;
				end else begin
					res_n.op_status = gtc_pkg::STATUS_FULL;
				end
			end
			gtc_pkg::FUNC_DELETE: begin
				res_n.result_kind = gtc_pkg::KIND_STATUS;
				if (p_hit_q) begin
					pol_we = fire;
					pol_wd.valid = 1'b0;
				end else begin
					res_n.op_status = gtc_pkg::STATUS_NOTFOUND;
				end
			end
			gtc_pkg::FUNC_READ: begin
				res_n.result_kind = gtc_pkg::KIND_COUNTERS;
				if (s_hit_q) begin
					res_n.packet_count = s_pkt_q;
					res_n.octet_count  = s_oct_q;
					res_n.drop_count   = s_drp_q;
				end else begin
					res_n.op_status = gtc_pkg::STATUS_NOTFOUND;
				end
			end
			default: begin
				res_n = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scan_q      <= '0;
			addr_s1     <= '0;
			issue_q     <= 1'b0;
			rd_vld_s1   <= 1'b0;
			last_s1     <= 1'b0;
			p_hit_q     <= 1'b0;
			p_free_q    <= 1'b0;
			s_hit_q     <= 1'b0;
			s_free_q    <= 1'b0;
			p_idx_q     <= '0;
			p_fidx_q    <= '0;
			s_idx_q     <= '0;
			s_fidx_q    <= '0;
			p_act_q     <= '0;
			p_cls_q     <= '0;
			s_pkt_q     <= '0;
			s_oct_q     <= '0;
			s_drp_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (scan_q == LAST_IDX) begin
						scan_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_IDLE: begin
					p_hit_q  <= 1'b0;
					p_free_q <= 1'b0;
					s_hit_q  <= 1'b0;
					s_free_q <= 1'b0;
					scan_q   <= '0;
					if (job_ready) begin
						if (job.func == gtc_pkg::FUNC_FRAME && !job.tunnel) begin
							state_q <= ST_APPLY;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= issue_q;
					addr_s1   <= scan_q;
					last_s1   <= (scan_q == LAST_IDX);
					if (issue_q) begin
						if (scan_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end else begin
							scan_q <= scan_q + 1'b1;
						end
					end
					if (rd_vld_s1) begin
						if (pol_rd_s1.valid && pol_rd_s1.key == job.key) begin
							p_hit_q <= 1'b1;
							p_idx_q <= addr_s1;
							p_act_q <= pol_rd_s1.act;
							p_cls_q <= pol_rd_s1.cls;
						end
						if (!pol_rd_s1.valid && !p_free_q) begin
							p_free_q <= 1'b1;
							p_fidx_q <= addr_s1;
						end
						if (st_rd_s1.valid && st_rd_s1.key == job.key) begin
							s_hit_q <= 1'b1;
							s_idx_q <= addr_s1;
							s_pkt_q <= st_rd_s1.pkt;
							s_oct_q <= st_rd_s1.oct;
							s_drp_q <= st_rd_s1.drp;
						end
						if (!st_rd_s1.valid && !s_free_q) begin
							s_free_q <= 1'b1;
							s_fidx_q <= addr_s1;
						end
						if (last_s1) begin
							rd_vld_s1 <= 1'b0;
							state_q   <= ST_APPLY;
						end
					end
				end
				ST_APPLY: begin
					if (fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/gtpu_teid_classifier.sv -----
// GTP-U tunnel classifier. Frame bytes are taken at one word per cycle while
// item_stall is low; the final byte of a frame, and every table operation,
// queues a job for the table engine, which scans TABLE_ENTRIES policy and
// stats slots, one per cycle; a non-tunnel frame skips the scan. After reset
// the tables are cleared while input stalls; configuration writes are taken
// at once. Reset is asynchronous.
module gtpu_teid_classifier #(
	parameter int unsigned TABLE_ENTRIES = 1024,
	parameter int unsigned HEADER_BYTES  = 96
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  gtc_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_stall,
	output gtc_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);

	// The GTP-U port register. The user must see that it is only written while the block is idle; the block
	// itself does not enforce it. So the parser may compare against it without any shadow copy.
	logic [15:0]          port_q;
	gtc_pkg::front_ctl_t  ctl;
	gtc_pkg::job_t        push_job, head;
	logic                 q_push, q_pop, q_full, q_nonempty, clearing;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q <= gtc_pkg::GTPU_PORT_DEF;
		end else if (cfg_valid && cfg_ready) begin
			port_q <= cfg_data;
		end
	end

	assign ctl.full     = q_full;
	assign ctl.clearing = clearing;

	// The parser runs at byte rate and only stalls when the job queue is full or the tables are being cleared.
	gtc_front #(.HEADER_BYTES(HEADER_BYTES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.item        (item),
		.tunnel_port (port_q),
		.ctl         (ctl),
		.job_push    (q_push),
		.job         (push_job)
	);

	gtc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head)
	);

	// The table engine works on the queue head in place and pops it when
	// the result word is loaded into its output register.
	gtc_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_ready    (q_nonempty),
		.job          (head),
		.job_pop      (q_pop),
		.clearing     (clearing),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full) else $error("job pushed into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty) else $error("job popped from an empty queue");

	a_plain_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.result_kind == gtc_pkg::KIND_VERDICT && !result.is_tunnel)
		|-> (result.frame_teid == 32'd0 && result.verdict == gtc_pkg::VERDICT_PASS))
		else $error("non-tunnel frame carries tunnel fields");

	a_mark_only: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.verdict != gtc_pkg::VERDICT_MARK)
		|-> (result.mark_value == 32'd0)) else $error("mark without mark verdict");
`endif

endmodule
